### rtl/core/bdlp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdlp_pkg
// Shared types and constants of the button debouncer with long press detect.
// ----------------------------------------------------------------------------
package bdlp_pkg;

    // configuration port geometry
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_HIGH = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ENABLED     = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE    = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS  = 4'd3;

    // register reset values
    localparam logic [CFG_DATA_W-1:0] DEBOUNCE_RESET   = 16'd100;
    localparam logic [CFG_DATA_W-1:0] LONG_PRESS_RESET = 16'd1000;

    // debounced button state
    typedef enum logic [1:0] {
        PS_RELEASED = 2'd0,
        PS_PRESSED  = 2'd1,
        PS_LONG     = 2'd2
    } press_state_t;

endpackage : bdlp_pkg
`default_nettype wire

### rtl/core/bdlp_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdlp_in_if
// Tick request channel: raw pin levels of all buttons for one tick.
// ----------------------------------------------------------------------------
interface bdlp_in_if #(
    parameter int NUM_BUTTONS = 4
);
    logic                   valid;
    logic                   ready;
    logic [NUM_BUTTONS-1:0] pin_levels;

    modport source (
        output valid,
        output pin_levels,
        input  ready
    );

    modport sink (
        input  valid,
        input  pin_levels,
        output ready
    );
endinterface : bdlp_in_if
`default_nettype wire

### rtl/core/bdlp_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdlp_out_if
// Report request channel: short, long and current pressed masks of one tick.
// ----------------------------------------------------------------------------
interface bdlp_out_if #(
    parameter int NUM_BUTTONS = 4
);
    logic                   valid;
    logic                   ready;
    logic [NUM_BUTTONS-1:0] short_press_mask;
    logic [NUM_BUTTONS-1:0] long_press_mask;
    logic [NUM_BUTTONS-1:0] pressed_now_mask;

    modport source (
        output valid,
        output short_press_mask,
        output long_press_mask,
        output pressed_now_mask,
        input  ready
    );

    modport sink (
        input  valid,
        input  short_press_mask,
        input  long_press_mask,
        input  pressed_now_mask,
        output ready
    );
endinterface : bdlp_out_if
`default_nettype wire

### rtl/core/button_debounce_long_press_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// button_debounce_long_press_top
// Debounces a group of buttons and reports short and long presses per tick.
// ----------------------------------------------------------------------------
// Usage
//   tick   : one request per millisecond tick carrying the raw pin levels,
//            bit i for button i.
//   report : one request per tick with the short press, long press and
//            current pressed masks of that tick.
//   cfg_*  : write port for polarity, enable, debounce and hold delays;
//            write only while no report is pending.
// Timing
//   All buttons are updated in parallel in the cycle a tick is taken; its
//   report is in the output register on the next cycle.
//   Throughput is one tick per cycle while report.ready is high, set by the single result register.
// Reset
//   All buttons released, timers idle, delays 100 and 1000; report masks are not reset.
// Backpressure
//   tick.ready is high while the result register is empty or being taken,
//   so a stalled receiver holds the report and stalls the tick side.
// ----------------------------------------------------------------------------
module button_debounce_long_press_top #(
    parameter int NUM_BUTTONS = 4,
    parameter int TIMER_WIDTH = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [bdlp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [bdlp_pkg::CFG_DATA_W-1:0]     cfg_data,
    bdlp_in_if.sink                                  tick,
    bdlp_out_if.source                               report
);

    localparam int EXT_W = TIMER_WIDTH + bdlp_pkg::CFG_DATA_W;

    // delay to counter load value, zero acts as one
    function automatic logic [TIMER_WIDTH-1:0] load_value(
        input logic [bdlp_pkg::CFG_DATA_W-1:0] v
    );
        logic [EXT_W-1:0]       ext;
        logic [TIMER_WIDTH-1:0] t;
        begin
            ext = {{TIMER_WIDTH{1'b0}}, v};
            t   = ext[TIMER_WIDTH-1:0];
            return (t == '0) ? TIMER_WIDTH'(1) : t;
        end
    endfunction

    // configuration registers
    logic [NUM_BUTTONS-1:0]              active_high_reg;
    logic [NUM_BUTTONS-1:0]              enabled_reg;
    logic [bdlp_pkg::CFG_DATA_W-1:0]     debounce_ticks_reg;
    logic [bdlp_pkg::CFG_DATA_W-1:0]     long_press_ticks_reg;

    // per button state
    bdlp_pkg::press_state_t              state_reg     [NUM_BUTTONS];
    bdlp_pkg::press_state_t              state_next    [NUM_BUTTONS];
    logic [TIMER_WIDTH-1:0]              dbc_reg       [NUM_BUTTONS];
    logic [TIMER_WIDTH-1:0]              dbc_next      [NUM_BUTTONS];
    logic [TIMER_WIDTH-1:0]              hold_reg      [NUM_BUTTONS];
    logic [TIMER_WIDTH-1:0]              hold_next     [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0]              rerun_reg;
    logic [NUM_BUTTONS-1:0]              rerun_next;
    logic [NUM_BUTTONS-1:0]              armed_rel_reg;
    logic [NUM_BUTTONS-1:0]              armed_rel_next;
    logic [NUM_BUTTONS-1:0]              prev_level_reg;
    logic [NUM_BUTTONS-1:0]              prev_level_next;

    // per button events of the current tick
    logic [NUM_BUTTONS-1:0]              level;
    logic [NUM_BUTTONS-1:0]              edge_hit;
    logic [NUM_BUTTONS-1:0]              rerun_fire;
    logic [NUM_BUTTONS-1:0]              dbc_expire;
    logic [NUM_BUTTONS-1:0]              fire;
    logic [NUM_BUTTONS-1:0]              hold_expire;
    bdlp_pkg::press_state_t              state_mid     [NUM_BUTTONS];

    // result register
    logic                                out_valid_reg;
    logic [NUM_BUTTONS-1:0]              short_reg;
    logic [NUM_BUTTONS-1:0]              short_next;
    logic [NUM_BUTTONS-1:0]              long_reg;
    logic [NUM_BUTTONS-1:0]              long_next;
    logic [NUM_BUTTONS-1:0]              now_reg;
    logic [NUM_BUTTONS-1:0]              now_next;

    logic                                tick_accept;

    // handshake
    assign tick.ready  = !out_valid_reg || report.ready;
    assign tick_accept = tick.valid && tick.ready;

    assign report.valid            = out_valid_reg;
    assign report.short_press_mask = short_reg;
    assign report.long_press_mask  = long_reg;
    assign report.pressed_now_mask = now_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_high_reg      <= '0;
            enabled_reg          <= '0;
            debounce_ticks_reg   <= bdlp_pkg::DEBOUNCE_RESET;
            long_press_ticks_reg <= bdlp_pkg::LONG_PRESS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bdlp_pkg::REG_ACTIVE_HIGH: active_high_reg      <= cfg_data[NUM_BUTTONS-1:0];
                bdlp_pkg::REG_ENABLED:     enabled_reg          <= cfg_data[NUM_BUTTONS-1:0];
                bdlp_pkg::REG_DEBOUNCE:    debounce_ticks_reg   <= cfg_data;
                bdlp_pkg::REG_LONG_PRESS:  long_press_ticks_reg <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // logical level, edge detect, debounce and hold timer events
    always_comb
    begin
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            level[i]       = active_high_reg[i] ? tick.pin_levels[i]
                                                : !tick.pin_levels[i];
            edge_hit[i]    = armed_rel_reg[i] ? (prev_level_reg[i] && !level[i])
                                              : (!prev_level_reg[i] && level[i]);
            rerun_fire[i]  = !edge_hit[i] && rerun_reg[i];
            dbc_expire[i]  = !edge_hit[i] && !rerun_reg[i]
                             && (dbc_reg[i] == TIMER_WIDTH'(1));
            fire[i]        = rerun_fire[i] || dbc_expire[i];
            hold_expire[i] = (hold_reg[i] == TIMER_WIDTH'(1));
            state_mid[i]   = hold_expire[i] ? bdlp_pkg::PS_LONG : state_reg[i];
        end
    end

    // next state per button
    always_comb
    begin
        prev_level_next = level;
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            state_next[i]     = state_reg[i];
            dbc_next[i]       = dbc_reg[i];
            hold_next[i]      = hold_reg[i];
            rerun_next[i]     = rerun_reg[i];
            armed_rel_next[i] = armed_rel_reg[i];
            if (enabled_reg[i])
            begin
                // debounce countdown
                if (edge_hit[i])
                begin
                    dbc_next[i]   = load_value(debounce_ticks_reg);
                    rerun_next[i] = 1'b0;
                end
                else if (rerun_reg[i])
                begin
                    rerun_next[i] = 1'b0;
                end
                else if (dbc_reg[i] != '0)
                begin
                    dbc_next[i] = dbc_reg[i] - TIMER_WIDTH'(1);
                end

                // hold timer
                if (hold_reg[i] != '0)
                begin
                    hold_next[i] = hold_reg[i] - TIMER_WIDTH'(1);
                end
                state_next[i] = state_mid[i];

                // debounced handler
                if (fire[i])
                begin
                    if (state_mid[i] != bdlp_pkg::PS_RELEASED)
                    begin
                        hold_next[i]  = '0;
                        state_next[i] = bdlp_pkg::PS_RELEASED;
                        if (!level[i])
                        begin
                            armed_rel_next[i] = 1'b0;
                        end
                        else
                        begin
                            rerun_next[i] = 1'b1;
                        end
                    end
                    else
                    begin
                        hold_next[i]  = load_value(long_press_ticks_reg);
                        state_next[i] = bdlp_pkg::PS_PRESSED;
                        if (level[i])
                        begin
                            armed_rel_next[i] = 1'b1;
                        end
                        else
                        begin
                            rerun_next[i] = 1'b1;
                        end
                    end
                end
            end
        end
    end

    // report masks
    always_comb
    begin
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            short_next[i] = enabled_reg[i] && fire[i]
                            && (state_mid[i] == bdlp_pkg::PS_PRESSED);
            long_next[i]  = enabled_reg[i] && hold_expire[i];
            now_next[i]   = enabled_reg[i] && level[i];
        end
    end

    // button state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                state_reg[i] <= bdlp_pkg::PS_RELEASED;
                dbc_reg[i]   <= '0;
                hold_reg[i]  <= '0;
            end
            rerun_reg      <= '0;
            armed_rel_reg  <= '0;
            prev_level_reg <= '0;
        end
        else if (tick_accept)
        begin
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                state_reg[i] <= state_next[i];
                dbc_reg[i]   <= dbc_next[i];
                hold_reg[i]  <= hold_next[i];
            end
            rerun_reg      <= rerun_next;
            armed_rel_reg  <= armed_rel_next;
            prev_level_reg <= prev_level_next;
        end
    end

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (tick.ready)
        begin
            out_valid_reg <= tick.valid;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (tick_accept)
        begin
            short_reg <= short_next;
            long_reg  <= long_next;
            now_reg   <= now_next;
        end
    end

`ifndef SYNTHESIS
    // a button never reports short and long press in one tick
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((short_reg & long_reg) == '0))
        else $error("short and long press reported together");

    // disabled buttons report nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (((short_reg | long_reg | now_reg) & ~enabled_reg) == '0))
        else $error("report from a disabled button");

    // every taken tick yields a report on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        tick_accept |=> out_valid_reg)
        else $error("tick taken without a report");

    // a running hold timer implies a plain press
    for (genvar g = 0; g < NUM_BUTTONS; g++)
    begin : g_hold_chk
        assert property (@(posedge clk) disable iff (!rst_n)
            (hold_reg[g] != '0) |-> (state_reg[g] == bdlp_pkg::PS_PRESSED))
            else $error("hold timer running outside pressed state");
    end
`endif

endmodule : button_debounce_long_press_top
`default_nettype wire
